/* hdl/stereo_fir_convolver_defines.svh */
// ----------------------------------------------------------------------------
// Stereo FIR convolver assertion macros
// Shared assertion wrappers; they expand to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef STEREO_FIR_CONVOLVER_DEFINES_SVH
`define STEREO_FIR_CONVOLVER_DEFINES_SVH
`ifndef SYNTHESIS
`define SFC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define SFC_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define SFC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SFC_ASSERT(lbl, prop, msg)
`define SFC_ASSERT_IMPLY(lbl, ante, cons, msg)
`define SFC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/sfc_pkg.sv */
// ----------------------------------------------------------------------------
// Stereo FIR convolver package
// Default sizes, fixed-point constants, codes and the control structs shared
// by the convolver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

   localparam int DEF_MAX_TAPS    = 8192;
   localparam int DEF_SAMPLE_BITS = 24;
   localparam int DEF_COEF_BITS   = 24;

   localparam int GAIN_W      = 16;
   localparam int GAIN_FRAC   = 14;
   localparam int ACC_W       = 64;
   localparam int ACC_SAT_EXP = 62;
   localparam int CLAMP_W     = 48;
   localparam int CLAMP_EXP   = 46;
   localparam int RISK_NUM    = 49;
   localparam int RISK_DEN    = 50;

   typedef enum logic [1:0] {
      FUNC_FRAME = 2'd0,
      FUNC_TAP   = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } sfc_func_type;

   typedef enum logic [2:0] {
      CSR_ENABLED   = 3'd0,
      CSR_TAP_COUNT = 3'd1,
      CSR_ACTIVE    = 3'd2,
      CSR_STEREO    = 3'd3,
      CSR_GAIN      = 3'd4
   } sfc_csr_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic ch;
   } sfc_tag_type;

   typedef struct packed {
      logic valid;
      logic ch;
      logic risk;
   } sfc_res_type;

endpackage

`default_nettype wire

/* hdl/stereo_fir_convolver.sv */
// ----------------------------------------------------------------------------
// Stereo FIR convolver
// Direct-form stereo FIR filter with circular sample histories, per-channel
// tap tables, trim gain, Q1.23 saturation and a sticky clip-risk flag.
//
// Port group   Direction   Handshake             Beat contents
// req_*        in          req_valid/req_stall   func, tap write, frame samples
// rsp_*        out         rsp_valid/rsp_stall   filtered samples, clip risk
// csr_*        in          csr_write             register index and data
//
// A filtered frame walks the T taps of each of its N filtered channels through the
// single multiply-accumulate unit, one tap per cycle.
// Tap writes and bypassed frames do not use that unit; a clear request zeroes the
// whole history, and a clearing pass also runs after reset.
// req_stall is high while a frame, a clearing pass or an unsent result is held.
// A result waits in the output register, so the next beat can be taken meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_fir_convolver_defines.svh"

module stereo_fir_convolver #(
   parameter int MAX_TAPS    = sfc_pkg::DEF_MAX_TAPS,
   parameter int SAMPLE_BITS = sfc_pkg::DEF_SAMPLE_BITS,
   parameter int COEF_BITS   = sfc_pkg::DEF_COEF_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [2:0]                             csr_index,
   input  logic [(($clog2(MAX_TAPS + 1) > sfc_pkg::GAIN_W) ?
                  $clog2(MAX_TAPS + 1) : sfc_pkg::GAIN_W)-1:0] csr_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_func,
   input  logic                                   req_tap_channel,
   input  logic [$clog2(MAX_TAPS)-1:0]            req_tap_index,
   input  logic signed [COEF_BITS-1:0]            req_tap_value,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample_left,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample_right,
   input  logic                                   req_end_of_block,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]          rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0]          rsp_out_right,
   output logic                                   rsp_clip_risk
);

   localparam int AW    = $clog2(MAX_TAPS);
   localparam int CNT_W = $clog2(MAX_TAPS + 1);

   localparam logic [sfc_pkg::GAIN_W-1:0] GAIN_RESET   = sfc_pkg::GAIN_W'(16384);
   localparam logic [1:0]                 ACTIVE_RESET = 2'd2;
   localparam logic [AW-1:0]              LAST_ADDR    = AW'(MAX_TAPS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   logic                          enabled_ff;
   logic [CNT_W-1:0]              tap_count_ff;
   logic [1:0]                    active_ff;
   logic                          stereo_ff;
   logic [sfc_pkg::GAIN_W-1:0]    gain_ff;

   state_type                     state_ff, state_in;
   logic [AW-1:0]                 clr_ptr_ff, clr_ptr_in;
   logic [AW-1:0]                 wp_ff, wp_in;
   logic [AW-1:0]                 rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]                 t_ff, t_in;
   logic                          ch_ff, ch_in;
   logic                          risk_acc_ff, risk_acc_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          nch2_ff, nch2_in;
   logic                          bypass_ff, bypass_in;
   logic                          eob_ff, eob_in;
   logic                          frame_risk_ff, frame_risk_in;
   logic [AW-1:0]                 last_t_ff, last_t_in;
   logic signed [SAMPLE_BITS-1:0] yl_ff, yl_in;
   logic signed [SAMPLE_BITS-1:0] yr_ff, yr_in;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_BITS-1:0] rsp_right_ff, rsp_right_in;
   logic                          rsp_risk_ff, rsp_risk_in;

   logic [CNT_W-1:0]              taps_eff;
   logic                          clip;
   logic                          hist_we_l;
   logic                          hist_we_r;
   logic [AW-1:0]                 hist_wr_addr;
   logic signed [SAMPLE_BITS-1:0] hist_wr_left;
   logic signed [SAMPLE_BITS-1:0] hist_wr_right;
   logic                          tap_we;
   sfc_pkg::sfc_tag_type          rd_tag;
   sfc_pkg::sfc_tag_type          st_tag;
   logic signed [SAMPLE_BITS-1:0] st_sample;
   logic signed [COEF_BITS-1:0]   st_coef;
   sfc_pkg::sfc_res_type          res;
   logic signed [SAMPLE_BITS-1:0] res_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         tap_count_ff <= '0;
         active_ff    <= ACTIVE_RESET;
         stereo_ff    <= 1'b0;
         gain_ff      <= GAIN_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            sfc_pkg::CSR_ENABLED:   enabled_ff   <= csr_data[0];
            sfc_pkg::CSR_TAP_COUNT: tap_count_ff <= csr_data[CNT_W-1:0];
            sfc_pkg::CSR_ACTIVE:    active_ff    <= csr_data[1:0];
            sfc_pkg::CSR_STEREO:    stereo_ff    <= csr_data[0];
            sfc_pkg::CSR_GAIN:      gain_ff      <= csr_data[sfc_pkg::GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      taps_eff = (tap_count_ff > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : tap_count_ff;
      clip     = !bypass_ff && (risk_acc_ff || frame_risk_ff);

      state_in      = state_ff;
      clr_ptr_in    = clr_ptr_ff;
      wp_in         = wp_ff;
      rd_ptr_in     = rd_ptr_ff;
      t_in          = t_ff;
      ch_in         = ch_ff;
      risk_acc_in   = risk_acc_ff;
      rsp_valid_in  = rsp_valid_ff;
      nch2_in       = nch2_ff;
      bypass_in     = bypass_ff;
      eob_in        = eob_ff;
      frame_risk_in = frame_risk_ff;
      last_t_in     = last_t_ff;
      yl_in         = yl_ff;
      yr_in         = yr_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_risk_in   = rsp_risk_ff;

      hist_we_l     = 1'b0;
      hist_we_r     = 1'b0;
      hist_wr_addr  = wp_ff;
      hist_wr_left  = req_sample_left;
      hist_wr_right = req_sample_right;
      tap_we        = 1'b0;
      rd_tag        = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (res.valid) begin
         if (res.ch) begin
            yr_in = res_value;
         end else begin
            yl_in = res_value;
         end
         frame_risk_in = frame_risk_ff || res.risk;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            hist_we_l     = 1'b1;
            hist_we_r     = 1'b1;
            hist_wr_addr  = clr_ptr_ff;
            hist_wr_left  = '0;
            hist_wr_right = '0;
            if (clr_ptr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               clr_ptr_in = clr_ptr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_func)
                  sfc_pkg::FUNC_FRAME: begin
                     yl_in         = req_sample_left;
                     yr_in         = req_sample_right;
                     eob_in        = req_end_of_block;
                     frame_risk_in = 1'b0;
                     nch2_in       = active_ff[1];
                     last_t_in     = AW'(taps_eff - CNT_W'(1));
                     bypass_in     = !enabled_ff || (tap_count_ff == '0);
                     if (!enabled_ff || (tap_count_ff == '0)) begin
                        state_in = ST_EMIT;
                     end else begin
                        hist_we_l = 1'b1;
                        hist_we_r = active_ff[1];
                        t_in      = '0;
                        ch_in     = 1'b0;
                        rd_ptr_in = wp_ff;
                        state_in  = ST_MAC;
                     end
                  end
                  sfc_pkg::FUNC_TAP: begin
                     tap_we = {1'b0, req_tap_index} < (AW + 1)'(MAX_TAPS);
                  end
                  sfc_pkg::FUNC_CLEAR: begin
                     clr_ptr_in  = '0;
                     wp_in       = '0;
                     risk_acc_in = 1'b0;
                     state_in    = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MAC: begin
            rd_tag.valid = 1'b1;
            rd_tag.first = (t_ff == '0);
            rd_tag.last  = (t_ff == last_t_ff);
            rd_tag.ch    = ch_ff;
            rd_ptr_in    = (rd_ptr_ff == '0) ? LAST_ADDR : rd_ptr_ff - AW'(1);
            t_in         = t_ff + AW'(1);
            if (t_ff == last_t_ff) begin
               if (!ch_ff && nch2_ff) begin
                  ch_in     = 1'b1;
                  t_in      = '0;
                  rd_ptr_in = wp_ff;
               end else begin
                  wp_in    = (wp_ff == LAST_ADDR) ? '0 : wp_ff + AW'(1);
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (res.valid && (res.ch == nch2_ff)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = yl_ff;
               rsp_right_in = yr_ff;
               rsp_risk_in  = clip;
               risk_acc_in  = eob_ff ? 1'b0 : clip;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      t_ff          <= t_in;
      ch_ff         <= ch_in;
      nch2_ff       <= nch2_in;
      bypass_ff     <= bypass_in;
      eob_ff        <= eob_in;
      frame_risk_ff <= frame_risk_in;
      last_t_ff     <= last_t_in;
      yl_ff         <= yl_in;
      yr_ff         <= yr_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_right_ff  <= rsp_right_in;
      rsp_risk_ff   <= rsp_risk_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         wp_ff        <= '0;
         risk_acc_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         wp_ff        <= wp_in;
         risk_acc_ff  <= risk_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   sfc_store #(
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_store (
      .clock         (clock),
      .reset         (reset),
      .hist_we_l     (hist_we_l),
      .hist_we_r     (hist_we_r),
      .hist_wr_addr  (hist_wr_addr),
      .hist_wr_left  (hist_wr_left),
      .hist_wr_right (hist_wr_right),
      .tap_we        (tap_we),
      .tap_wr_ch     (req_tap_channel),
      .tap_wr_addr   (req_tap_index),
      .tap_wr_data   (req_tap_value),
      .rd_tag        (rd_tag),
      .rd_hist_addr  (rd_ptr_ff),
      .rd_tap_addr   (t_ff),
      .rd_tap_ch     (stereo_ff && ch_ff),
      .out_tag       (st_tag),
      .out_sample    (st_sample),
      .out_coef      (st_coef)
   );

   sfc_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_tag    (st_tag),
      .in_sample (st_sample),
      .in_coef   (st_coef),
      .gain      (gain_ff),
      .res       (res),
      .res_value (res_value)
   );

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_left  = rsp_left_ff;
   assign rsp_out_right = rsp_right_ff;
   assign rsp_clip_risk = rsp_risk_ff;

   `SFC_ASSERT_IMPLY(a_res_in_frame, res.valid, state_ff == ST_MAC || state_ff == ST_DRAIN, "channel result outside a frame")
   `SFC_ASSERT_IMPLY(a_idle_drained, state_ff == ST_IDLE, !st_tag.valid, "read still in flight while idle")
   `SFC_ASSERT_NEXT(a_emit_waits, state_ff == ST_EMIT && rsp_valid_ff && rsp_stall, state_ff == ST_EMIT, "pending result overwritten")

endmodule

`default_nettype wire

/* hdl/sfc_store.sv */
// ----------------------------------------------------------------------------
// Stereo FIR convolver sample and tap storage
// Two circular sample histories and two tap tables, each a single-port-write,
// registered-read memory, with the channel selects applied after the read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfc_store #(
   parameter int MAX_TAPS    = sfc_pkg::DEF_MAX_TAPS,
   parameter int SAMPLE_BITS = sfc_pkg::DEF_SAMPLE_BITS,
   parameter int COEF_BITS   = sfc_pkg::DEF_COEF_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          hist_we_l,
   input  logic                          hist_we_r,
   input  logic [$clog2(MAX_TAPS)-1:0]   hist_wr_addr,
   input  logic signed [SAMPLE_BITS-1:0] hist_wr_left,
   input  logic signed [SAMPLE_BITS-1:0] hist_wr_right,
   input  logic                          tap_we,
   input  logic                          tap_wr_ch,
   input  logic [$clog2(MAX_TAPS)-1:0]   tap_wr_addr,
   input  logic signed [COEF_BITS-1:0]   tap_wr_data,
   input  sfc_pkg::sfc_tag_type          rd_tag,
   input  logic [$clog2(MAX_TAPS)-1:0]   rd_hist_addr,
   input  logic [$clog2(MAX_TAPS)-1:0]   rd_tap_addr,
   input  logic                          rd_tap_ch,
   output sfc_pkg::sfc_tag_type          out_tag,
   output logic signed [SAMPLE_BITS-1:0] out_sample,
   output logic signed [COEF_BITS-1:0]   out_coef
);

   logic signed [SAMPLE_BITS-1:0] hist_l_ff [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] hist_r_ff [MAX_TAPS];
   logic signed [COEF_BITS-1:0]   tap0_ff [MAX_TAPS];
   logic signed [COEF_BITS-1:0]   tap1_ff [MAX_TAPS];

   logic signed [SAMPLE_BITS-1:0] hist_l_rd_ff;
   logic signed [SAMPLE_BITS-1:0] hist_r_rd_ff;
   logic signed [COEF_BITS-1:0]   tap0_rd_ff;
   logic signed [COEF_BITS-1:0]   tap1_rd_ff;
   logic                          tap_ch_ff;
   sfc_pkg::sfc_tag_type          tag_ff;

   always_ff @(posedge clock) begin
      if (hist_we_l) begin
         hist_l_ff[hist_wr_addr] <= hist_wr_left;
      end
      hist_l_rd_ff <= hist_l_ff[rd_hist_addr];
   end

   always_ff @(posedge clock) begin
      if (hist_we_r) begin
         hist_r_ff[hist_wr_addr] <= hist_wr_right;
      end
      hist_r_rd_ff <= hist_r_ff[rd_hist_addr];
   end

   always_ff @(posedge clock) begin
      if (tap_we && !tap_wr_ch) begin
         tap0_ff[tap_wr_addr] <= tap_wr_data;
      end
      tap0_rd_ff <= tap0_ff[rd_tap_addr];
   end

   always_ff @(posedge clock) begin
      if (tap_we && tap_wr_ch) begin
         tap1_ff[tap_wr_addr] <= tap_wr_data;
      end
      tap1_rd_ff <= tap1_ff[rd_tap_addr];
   end

   always_ff @(posedge clock) begin
      tap_ch_ff <= rd_tap_ch;
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= rd_tag;
      end
   end

   assign out_tag    = tag_ff;
   assign out_sample = tag_ff.ch ? hist_r_rd_ff : hist_l_rd_ff;
   assign out_coef   = tap_ch_ff ? tap1_rd_ff : tap0_rd_ff;

endmodule

`default_nettype wire

/* hdl/sfc_mac.sv */
// ----------------------------------------------------------------------------
// Stereo FIR convolver multiply-accumulate unit
// One shared multiplier and saturating accumulator, followed by a pipelined
// finish: round to sample precision, clamp, trim gain, saturate, risk check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_fir_convolver_defines.svh"

module sfc_mac #(
   parameter int SAMPLE_BITS = sfc_pkg::DEF_SAMPLE_BITS,
   parameter int COEF_BITS   = sfc_pkg::DEF_COEF_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sfc_pkg::sfc_tag_type              in_tag,
   input  logic signed [SAMPLE_BITS-1:0]     in_sample,
   input  logic signed [COEF_BITS-1:0]       in_coef,
   input  logic [sfc_pkg::GAIN_W-1:0]        gain,
   output sfc_pkg::sfc_res_type              res,
   output logic signed [SAMPLE_BITS-1:0]     res_value
);

   localparam int PW = SAMPLE_BITS + COEF_BITS;
   localparam int AW = sfc_pkg::ACC_W;
   localparam int CW = sfc_pkg::CLAMP_W;
   localparam int SW = sfc_pkg::CLAMP_W + sfc_pkg::GAIN_W + 1;
   localparam int RW = SAMPLE_BITS + 7;

   localparam logic signed [AW-1:0] ACC_ONE   = {{(AW-1){1'b0}}, 1'b1};
   localparam logic signed [AW-1:0] ACC_LIM   = ACC_ONE <<< sfc_pkg::ACC_SAT_EXP;
   localparam logic signed [AW-1:0] ACC_RND   = ACC_ONE <<< (COEF_BITS - 2);
   localparam logic signed [AW-1:0] CLAMP_LIM = ACC_ONE <<< sfc_pkg::CLAMP_EXP;
   localparam logic signed [SW-1:0] S_ONE     = {{(SW-1){1'b0}}, 1'b1};
   localparam logic signed [SW-1:0] GAIN_RND  = S_ONE <<< (sfc_pkg::GAIN_FRAC - 1);
   localparam logic signed [SW-1:0] SMAX      = (S_ONE <<< (SAMPLE_BITS - 1)) - S_ONE;
   localparam logic signed [SW-1:0] SMIN      = -(S_ONE <<< (SAMPLE_BITS - 1));
   localparam logic [RW-1:0]        RISK_THR  = RW'(sfc_pkg::RISK_NUM) << (SAMPLE_BITS - 1);

   logic signed [PW-1:0]          prod_ff;
   sfc_pkg::sfc_tag_type          ptag_ff;
   logic signed [AW-1:0]          acc_ff;
   logic                          acc_valid_ff;
   logic                          acc_last_ff;
   logic                          acc_ch_ff;
   logic signed [CW-1:0]          f1_ff;
   logic                          f1_valid_ff;
   logic                          f1_ch_ff;
   logic signed [SW-1:0]          f2_ff;
   logic                          f2_valid_ff;
   logic                          f2_ch_ff;
   logic signed [SAMPLE_BITS-1:0] f3_ff;
   logic                          f3_valid_ff;
   logic                          f3_ch_ff;
   logic signed [SAMPLE_BITS-1:0] res_value_ff;
   sfc_pkg::sfc_res_type          res_ff;

   logic signed [PW-1:0]          prod_in;
   logic signed [AW-1:0]          p_ext;
   logic signed [AW-1:0]          acc_sum;
   logic signed [AW-1:0]          acc_in;
   logic signed [AW-1:0]          rnd_sum;
   logic signed [AW-1:0]          rnd_full;
   logic signed [CW-1:0]          f1_in;
   logic signed [sfc_pkg::GAIN_W:0] gain_s;
   logic signed [SW-1:0]          f2_in;
   logic signed [SW-1:0]          g_sum;
   logic signed [SW-1:0]          g_sh;
   logic signed [SAMPLE_BITS-1:0] f3_in;
   logic signed [SAMPLE_BITS:0]   f3_ext;
   logic [SAMPLE_BITS:0]          mag;
   logic [RW-1:0]                 mag_scaled;
   logic                          risk_in;

   always_comb begin
      prod_in = in_sample * in_coef;

      p_ext   = AW'(prod_ff);
      acc_sum = acc_ff + p_ext;
      if (ptag_ff.first) begin
         acc_in = p_ext;
      end else if (acc_sum > ACC_LIM) begin
         acc_in = ACC_LIM;
      end else if (acc_sum < -ACC_LIM) begin
         acc_in = -ACC_LIM;
      end else begin
         acc_in = acc_sum;
      end

      rnd_sum  = acc_ff + ACC_RND;
      rnd_full = rnd_sum >>> (COEF_BITS - 1);
      if (rnd_full > CLAMP_LIM) begin
         f1_in = CW'(CLAMP_LIM);
      end else if (rnd_full < -CLAMP_LIM) begin
         f1_in = CW'(-CLAMP_LIM);
      end else begin
         f1_in = CW'(rnd_full);
      end

      gain_s = signed'({1'b0, gain});
      f2_in  = f1_ff * gain_s;

      g_sum = f2_ff + GAIN_RND;
      g_sh  = g_sum >>> sfc_pkg::GAIN_FRAC;
      if (g_sh > SMAX) begin
         f3_in = SAMPLE_BITS'(SMAX);
      end else if (g_sh < SMIN) begin
         f3_in = SAMPLE_BITS'(SMIN);
      end else begin
         f3_in = SAMPLE_BITS'(g_sh);
      end

      f3_ext     = {f3_ff[SAMPLE_BITS-1], f3_ff};
      mag        = f3_ext[SAMPLE_BITS] ? unsigned'(-f3_ext) : unsigned'(f3_ext);
      mag_scaled = RW'(mag) * RW'(sfc_pkg::RISK_DEN);
      risk_in    = mag_scaled > RISK_THR;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ptag_ff.valid) begin
         acc_ff <= acc_in;
      end
      acc_last_ff  <= ptag_ff.last;
      acc_ch_ff    <= ptag_ff.ch;
      f1_ff        <= f1_in;
      f1_ch_ff     <= acc_ch_ff;
      f2_ff        <= f2_in;
      f2_ch_ff     <= f1_ch_ff;
      f3_ff        <= f3_in;
      f3_ch_ff     <= f2_ch_ff;
      res_value_ff <= f3_ff;
      if (reset) begin
         ptag_ff      <= '0;
         acc_valid_ff <= 1'b0;
         f1_valid_ff  <= 1'b0;
         f2_valid_ff  <= 1'b0;
         f3_valid_ff  <= 1'b0;
         res_ff       <= '0;
      end else begin
         ptag_ff      <= in_tag;
         acc_valid_ff <= ptag_ff.valid;
         f1_valid_ff  <= acc_valid_ff && acc_last_ff;
         f2_valid_ff  <= f1_valid_ff;
         f3_valid_ff  <= f2_valid_ff;
         res_ff.valid <= f3_valid_ff;
         res_ff.ch    <= f3_ch_ff;
         res_ff.risk  <= risk_in;
      end
   end

   assign res       = res_ff;
   assign res_value = res_value_ff;

   `SFC_ASSERT_IMPLY(a_acc_bounded, acc_valid_ff, acc_ff <= ACC_LIM && acc_ff >= -ACC_LIM, "accumulator outside saturation range")
   `SFC_ASSERT_NEXT(a_last_finishes, acc_valid_ff && acc_last_ff, f1_valid_ff, "final sum did not enter the finish pipeline")

endmodule

`default_nettype wire

/* sim/tb_stereo_fir_convolver.sv */
// ----------------------------------------------------------------------------
// Stereo FIR convolver testbench
// Drives tap writes, history clears and frames through the request channel,
// predicts every frame result with an independent fixed-point filter model
// and compares each accepted result field by field. Short directed tests
// cover bypass, saturation, clip risk, channel modes and history clearing.
// Randomized phases vary the settings and the idle behavior of both sides,
// and a final test covers long output back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stereo_fir_convolver;

   localparam int MAX_TAPS     = sfc_pkg::DEF_MAX_TAPS;
   localparam int SAMPLE_W     = sfc_pkg::DEF_SAMPLE_BITS;
   localparam int COEF_W       = sfc_pkg::DEF_COEF_BITS;
   localparam int INDEX_W      = $clog2(MAX_TAPS);
   localparam int COUNT_W      = $clog2(MAX_TAPS + 1);
   localparam int CSR_W        = (COUNT_W > sfc_pkg::GAIN_W) ? COUNT_W : sfc_pkg::GAIN_W;
   localparam int UNITY_GAIN   = 1 << sfc_pkg::GAIN_FRAC;
   localparam int MAX_GAIN     = (1 << sfc_pkg::GAIN_W) - 1;
   localparam int BEAT_SETTLE  = 16;
   localparam int CLEAR_SETTLE = MAX_TAPS + 64;
   localparam int WATCHDOG_LIMIT = 4 * (2 * MAX_TAPS + 64);
   localparam int RANDOM_BEATS = 50;
   localparam logic [2:0] CSR_UNMAPPED = 3'd7;
   localparam longint ACC_LIMIT   = longint'(1) <<< sfc_pkg::ACC_SAT_EXP;
   localparam longint CLAMP_LIMIT = longint'(1) <<< sfc_pkg::CLAMP_EXP;
   localparam longint SAMPLE_MAX  = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_MIN  = -(longint'(1) <<< (SAMPLE_W - 1));
   localparam logic signed [SAMPLE_W-1:0] FULL_NEG = {1'b1, {(SAMPLE_W - 1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] FULL_POS = {1'b0, {(SAMPLE_W - 1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] HALF_POS = {2'b01, {(SAMPLE_W - 2){1'b0}}};

   typedef struct {
      sfc_pkg::sfc_func_type       func;
      logic                        tap_channel;
      logic [INDEX_W-1:0]          tap_index;
      logic signed [COEF_W-1:0]    tap_value;
      logic signed [SAMPLE_W-1:0]  sample_left;
      logic signed [SAMPLE_W-1:0]  sample_right;
      logic                        end_of_block;
   } fir_request_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       clip_risk;
   } frame_output_type;

   logic                        clock;
   logic                        reset            = 1'b1;
   logic                        csr_write        = 1'b0;
   logic [2:0]                  csr_index        = '0;
   logic [CSR_W-1:0]            csr_data         = '0;
   logic                        req_valid        = 1'b0;
   logic                        req_stall;
   logic [1:0]                  req_func         = '0;
   logic                        req_tap_channel  = 1'b0;
   logic [INDEX_W-1:0]          req_tap_index    = '0;
   logic signed [COEF_W-1:0]    req_tap_value    = '0;
   logic signed [SAMPLE_W-1:0]  req_sample_left  = '0;
   logic signed [SAMPLE_W-1:0]  req_sample_right = '0;
   logic                        req_end_of_block = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall        = 1'b0;
   logic signed [SAMPLE_W-1:0]  rsp_out_left;
   logic signed [SAMPLE_W-1:0]  rsp_out_right;
   logic                        rsp_clip_risk;

   bit          cfg_enabled     = 1'b0;
   int          cfg_tap_count   = 0;
   int          cfg_active      = 2;
   bit          cfg_stereo      = 1'b0;
   int          cfg_gain        = UNITY_GAIN;

   logic signed [SAMPLE_W-1:0] sample_hist [2][MAX_TAPS];
   logic signed [COEF_W-1:0]   tap_coef    [2][MAX_TAPS];
   bit                         tap_loaded  [2][MAX_TAPS];
   int                         hist_pos;
   bit                         risk_sticky;

   frame_output_type expected_frames [$];
   int error_count   = 0;
   int settle_need   = BEAT_SETTLE;
   int send_idle_pct = 22;
   int recv_idle_pct = 54;
   int hold_request  = 0;
   int hold_left     = 0;
   int idle_cycles   = 0;

   stereo_fir_convolver dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_tap_channel  (req_tap_channel),
      .req_tap_index    (req_tap_index),
      .req_tap_value    (req_tap_value),
      .req_sample_left  (req_sample_left),
      .req_sample_right (req_sample_right),
      .req_end_of_block (req_end_of_block),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_left     (rsp_out_left),
      .rsp_out_right    (rsp_out_right),
      .rsp_clip_risk    (rsp_clip_risk)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void clear_history();
      for (int ch = 0; ch < 2; ch++)
         for (int i = 0; i < MAX_TAPS; i++)
            sample_hist[ch][i] = '0;
      hist_pos    = 0;
      risk_sticky = 1'b0;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] convolve_channel(input int ch,
                                                                   input int n_taps,
                                                                   inout bit risk);
      int     tch;
      int     idx;
      longint acc;
      longint v;
      longint mag;
      tch = cfg_stereo ? ch : 0;
      acc = 0;
      for (int t = 0; t < n_taps; t++) begin
         idx = (hist_pos >= t) ? hist_pos - t : hist_pos + MAX_TAPS - t;
         acc += longint'(sample_hist[ch][idx]) * longint'(tap_coef[tch][t]);
         if (acc > ACC_LIMIT) acc = ACC_LIMIT;
         else if (acc < -ACC_LIMIT) acc = -ACC_LIMIT;
      end
      v = (acc + (longint'(1) <<< (COEF_W - 2))) >>> (COEF_W - 1);
      if (v > CLAMP_LIMIT) v = CLAMP_LIMIT;
      else if (v < -CLAMP_LIMIT) v = -CLAMP_LIMIT;
      v = (v * longint'(cfg_gain) + (longint'(1) <<< (sfc_pkg::GAIN_FRAC - 1)))
          >>> sfc_pkg::GAIN_FRAC;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      else if (v < SAMPLE_MIN) v = SAMPLE_MIN;
      mag = (v < 0) ? -v : v;
      if (sfc_pkg::RISK_DEN * mag > sfc_pkg::RISK_NUM * (longint'(1) <<< (SAMPLE_W - 1)))
         risk = 1'b1;
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic void predict_request(input fir_request_type r);
      frame_output_type res;
      int               n_taps;
      bit               risk;
      case (r.func)
         sfc_pkg::FUNC_TAP: begin
            tap_coef[r.tap_channel][r.tap_index]   = r.tap_value;
            tap_loaded[r.tap_channel][r.tap_index] = 1'b1;
            if (settle_need < BEAT_SETTLE) settle_need = BEAT_SETTLE;
         end
         sfc_pkg::FUNC_CLEAR: begin
            clear_history();
            settle_need = CLEAR_SETTLE;
         end
         sfc_pkg::FUNC_FRAME: begin
            n_taps    = (cfg_tap_count > MAX_TAPS) ? MAX_TAPS : cfg_tap_count;
            res.left  = r.sample_left;
            res.right = r.sample_right;
            risk      = 1'b0;
            if (!cfg_enabled || n_taps == 0) begin
               risk_sticky = 1'b0;
            end else begin
               sample_hist[0][hist_pos] = r.sample_left;
               if (cfg_active >= 2) sample_hist[1][hist_pos] = r.sample_right;
               res.left = convolve_channel(0, n_taps, risk);
               if (cfg_active >= 2) res.right = convolve_channel(1, n_taps, risk);
               hist_pos = (hist_pos + 1) % MAX_TAPS;
               if (risk) risk_sticky = 1'b1;
            end
            res.clip_risk = risk_sticky;
            if (r.end_of_block) risk_sticky = 1'b0;
            expected_frames = {expected_frames, res};
            settle_need = BEAT_SETTLE;
         end
         default: begin
            if (settle_need < BEAT_SETTLE) settle_need = BEAT_SETTLE;
         end
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      logic [31:0] w;
      w = $urandom();
      case ($urandom_range(0, 7))
         0:       return FULL_NEG;
         1:       return FULL_POS;
         default: return w[SAMPLE_W-1:0];
      endcase
   endfunction

   function automatic fir_request_type random_request(input sfc_pkg::sfc_func_type f);
      fir_request_type r;
      r.func         = f;
      r.tap_channel  = $urandom_range(0, 1);
      r.tap_index    = $urandom_range(0, MAX_TAPS - 1);
      r.tap_value    = random_sample();
      r.sample_left  = random_sample();
      r.sample_right = random_sample();
      r.end_of_block = ($urandom_range(0, 3) == 0);
      return r;
   endfunction

   task automatic send_request(input fir_request_type r);
      @(negedge clock);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_func         <= r.func;
      req_tap_channel  <= r.tap_channel;
      req_tap_index    <= r.tap_index;
      req_tap_value    <= r.tap_value;
      req_sample_left  <= r.sample_left;
      req_sample_right <= r.sample_right;
      req_end_of_block <= r.end_of_block;
      req_valid        <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(r);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (settle_need) @(posedge clock);
      settle_need = BEAT_SETTLE;
   endtask

   task automatic write_csr(input logic [2:0] idx, input int value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_W-1:0];
   endtask

   task automatic write_settings(input bit en, input int count, input int chans,
                                 input bit stereo, input int gain);
      wait_idle();
      write_csr(sfc_pkg::CSR_ENABLED, en);
      write_csr(sfc_pkg::CSR_TAP_COUNT, count);
      write_csr(sfc_pkg::CSR_ACTIVE, chans);
      write_csr(sfc_pkg::CSR_STEREO, stereo);
      write_csr(sfc_pkg::CSR_GAIN, gain);
      write_csr(CSR_UNMAPPED, $urandom_range(0, MAX_GAIN));
      @(negedge clock);
      csr_write     <= 1'b0;
      cfg_enabled   = en;
      cfg_tap_count = count;
      cfg_active    = chans;
      cfg_stereo    = stereo;
      cfg_gain      = gain;
   endtask

   // Taps that the current settings will read are written before any frame uses them.
   task automatic load_missing_taps(input int shift);
      fir_request_type r;
      int              n;
      n = (cfg_tap_count > MAX_TAPS) ? MAX_TAPS : cfg_tap_count;
      for (int ch = 0; ch < (cfg_stereo ? 2 : 1); ch++)
         for (int t = 0; t < n; t++)
            if (!tap_loaded[ch][t]) begin
               r             = random_request(sfc_pkg::FUNC_TAP);
               r.tap_channel = ch;
               r.tap_index   = t;
               r.tap_value   = r.tap_value >>> shift;
               send_request(r);
            end
   endtask

   task automatic send_frame(input logic signed [SAMPLE_W-1:0] left,
                             input logic signed [SAMPLE_W-1:0] right, input bit eob);
      fir_request_type r;
      r              = random_request(sfc_pkg::FUNC_FRAME);
      r.sample_left  = left;
      r.sample_right = right;
      r.end_of_block = eob;
      send_request(r);
   endtask

   task automatic send_tap(input bit ch, input int idx, input logic signed [COEF_W-1:0] value);
      fir_request_type r;
      r             = random_request(sfc_pkg::FUNC_TAP);
      r.tap_channel = ch;
      r.tap_index   = idx;
      r.tap_value   = value;
      send_request(r);
   endtask

   task automatic test_bypass_after_reset();
      send_frame(FULL_NEG, FULL_POS, 1'b0);
      send_frame(FULL_POS, FULL_NEG, 1'b1);
   endtask

   task automatic test_saturation_and_risk();
      send_tap(1'b0, 0, FULL_NEG);
      send_tap(1'b0, 1, FULL_POS);
      send_tap(1'b1, 0, HALF_POS);
      send_tap(1'b1, 1, random_sample());
      write_settings(1'b1, 2, 2, 1'b1, UNITY_GAIN);
      send_frame(FULL_NEG, FULL_NEG, 1'b0);
      send_frame(FULL_POS, '0, 1'b1);
      send_frame(random_sample(), random_sample(), 1'b0);
   endtask

   task automatic test_channel_modes();
      write_settings(1'b1, 2, 1, 1'b0, MAX_GAIN);
      send_frame(random_sample(), random_sample(), 1'b0);
      send_frame(FULL_NEG, FULL_POS, 1'b1);
      write_settings(1'b1, 2, 0, 1'b1, 0);
      send_frame(random_sample(), random_sample(), 1'b0);
      write_settings(1'b1, 2, 3, 1'b0, UNITY_GAIN);
      send_frame(random_sample(), random_sample(), 1'b0);
      write_settings(1'b1, 0, 2, 1'b1, UNITY_GAIN);
      send_frame(FULL_NEG, FULL_NEG, 1'b0);
   endtask

   task automatic test_history_clear();
      write_settings(1'b1, 2, 2, 1'b1, UNITY_GAIN);
      send_frame(FULL_NEG, FULL_NEG, 1'b0);
      send_request(random_request(sfc_pkg::FUNC_NONE));
      send_request(random_request(sfc_pkg::FUNC_CLEAR));
      send_frame(random_sample(), random_sample(), 1'b0);
      send_frame(random_sample(), random_sample(), 1'b1);
   endtask

   task automatic test_random_traffic();
      fir_request_type r;
      int              sent;
      int              pick;
      int              count;
      int              gain;
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         if (sent >= 2 * RANDOM_BEATS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (sent >= RANDOM_BEATS / 3) begin
            send_idle_pct = 54;
            recv_idle_pct = 22;
         end
         count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
         case ($urandom_range(0, 4))
            0:       gain = 0;
            1:       gain = MAX_GAIN;
            2:       gain = UNITY_GAIN;
            default: gain = $urandom_range(0, MAX_GAIN);
         endcase
         write_settings($urandom_range(0, 9) != 0, count, $urandom_range(0, 3),
                        $urandom_range(0, 1), gain);
         load_missing_taps(0);
         repeat ($urandom_range(6, 14)) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) r = random_request(sfc_pkg::FUNC_FRAME);
            else if (pick < 90) r = random_request(sfc_pkg::FUNC_TAP);
            else if (pick < 95) r = random_request(sfc_pkg::FUNC_CLEAR);
            else r = random_request(sfc_pkg::FUNC_NONE);
            send_request(r);
            if (r.func != sfc_pkg::FUNC_NONE) sent++;
         end
      end
   endtask

   task automatic test_output_backpressure();
      write_settings(1'b1, 4, 2, 1'b1, UNITY_GAIN);
      load_missing_taps(0);
      hold_request = 300;
      repeat (10) send_request(random_request(sfc_pkg::FUNC_FRAME));
      wait_idle();
      repeat (4) send_request(random_request(sfc_pkg::FUNC_FRAME));
   endtask

   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      frame_output_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual %0d %0d %0b", $time,
                     rsp_out_left, rsp_out_right, rsp_clip_risk);
         end else begin
            want = expected_frames.pop_front();
            if (rsp_out_left !== want.left) begin
               error_count++;
               $display("%0t: out_left mismatch, expected %0d, actual %0d", $time,
                        want.left, rsp_out_left);
            end
            if (rsp_out_right !== want.right) begin
               error_count++;
               $display("%0t: out_right mismatch, expected %0d, actual %0d", $time,
                        want.right, rsp_out_right);
            end
            if (rsp_clip_risk !== want.clip_risk) begin
               error_count++;
               $display("%0t: clip_risk mismatch, expected %0b, actual %0b", $time,
                        want.clip_risk, rsp_clip_risk);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clear_history();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bypass_after_reset();
      test_saturation_and_risk();
      test_channel_modes();
      test_history_clear();
      test_random_traffic();
      test_output_backpressure();
      wait_idle();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/sfc_pkg.sv
hdl/sfc_store.sv
hdl/sfc_mac.sv
hdl/stereo_fir_convolver.sv
sim/tb_stereo_fir_convolver.sv
